/* rtl/mrrc_pkg.sv */
// Shared types and constants for the range rule classifier.
package mrrc_pkg;

    // Request action codes.
    typedef enum logic [1:0] {
        ACT_WR_LO  = 2'd0,
        ACT_WR_HI  = 2'd1,
        ACT_FIELD  = 2'd2,
        ACT_REPORT = 2'd3
    } t_action;

    // Result kind codes.
    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_COUNT   = 1'b1;

    // Unsigned Q1.16 value of 1.0, the saturation limit.
    localparam logic [16:0] Q_ONE = 17'h10000;

    // Largest hit count.
    localparam logic [31:0] HITS_MAX = 32'hFFFF_FFFF;

    // Number of rules that can be addressed and reported.
    localparam int MAX_RULES = 8;

    // One input request.
    typedef struct packed {
        t_action     action;
        logic [2:0]  rule_index;
        logic [2:0]  field_index;
        logic [16:0] value;
        logic        last_field;
    } t_req;

    // One result item.
    typedef struct packed {
        logic        kind;
        logic [7:0]  match_mask;
        logic [2:0]  rule_number;
        logic [31:0] match_count;
        logic        last;
    } t_res;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       wr_bound;
        logic       capture;
        logic       scan_rd;
        logic       emit_verdict;
        logic       emit_count;
        logic       last_count;
        logic [2:0] idx;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic field_ok;
        logic req_last;
        logic cur_last;
    } t_status;

endpackage

/* rtl/mrrc_ctrl.sv */
// Controller state machine for the range rule classifier.
module mrrc_ctrl #(
    parameter int RULE_COUNT = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  mrrc_pkg::t_action i_action,
    input  mrrc_pkg::t_status i_status,
    output logic              o_busy,
    output mrrc_pkg::t_cmd    o_cmd
);
    import mrrc_pkg::*;

    localparam int ACTIVE = (RULE_COUNT < MAX_RULES) ? RULE_COUNT : MAX_RULES;
    localparam int RW     = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;
    localparam logic [RW-1:0] IDX_END = RW'(ACTIVE - 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DRAIN  = 5'b00100,
        ST_EMIT   = 5'b01000,
        ST_REPORT = 5'b10000
    } t_state;

    t_state        r_state, n_state;
    logic [RW-1:0] r_idx, n_idx;

    // Next state, rule counter and datapath commands.
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_cmd   = '0;
        o_cmd.idx = 3'(r_idx);
        unique case (r_state)
            ST_IDLE: begin
                n_idx = '0;
                if (i_start) begin
                    unique case (i_action)
                        ACT_WR_LO, ACT_WR_HI: begin
                            o_cmd.wr_bound = 1'b1;
                        end
                        ACT_FIELD: begin
                            o_cmd.capture = 1'b1;
                            if (i_status.field_ok) begin
                                n_state = ST_SCAN;
                            end else if (i_status.req_last) begin
                                n_state = ST_EMIT;
                            end
                        end
                        ACT_REPORT: begin
                            n_state = ST_REPORT;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (r_idx == IDX_END) begin
                    n_idx   = '0;
                    n_state = ST_DRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_DRAIN: begin
                // The final rule's compare lands in this cycle.
                n_state = i_status.cur_last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                o_cmd.emit_verdict = 1'b1;
                n_state = ST_IDLE;
            end
            ST_REPORT: begin
                o_cmd.emit_count = 1'b1;
                if (r_idx == IDX_END) begin
                    o_cmd.last_count = 1'b1;
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

/* rtl/mrrc_dp.sv */
// Datapath for the range rule classifier: bound memories, match and hit state, result register.
module mrrc_dp #(
    parameter int FIELD_COUNT = 8,
    parameter int RULE_COUNT  = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mrrc_pkg::t_req    i_req,
    input  mrrc_pkg::t_cmd    i_cmd,
    output mrrc_pkg::t_status o_status,
    output logic              o_res_strobe,
    output mrrc_pkg::t_res    o_res
);
    import mrrc_pkg::*;

    localparam int ACTIVE = (RULE_COUNT < MAX_RULES) ? RULE_COUNT : MAX_RULES;
    localparam int RW     = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;
    localparam int DEPTH  = RULE_COUNT * FIELD_COUNT;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [7:0]    ACTIVE_MASK = 8'((1 << ACTIVE) - 1);
    localparam logic [AW-1:0] FIELD_STEP  = AW'(FIELD_COUNT);

    // Bound memories, one entry per rule and field.
    logic [16:0] r_lo_mem [DEPTH];
    logic [16:0] r_hi_mem [DEPTH];

    logic [16:0] sat_value;
    logic        rule_ok;
    logic        field_ok;
    logic [AW-1:0] wr_addr;

    logic [AW-1:0] r_addr;
    logic [16:0]   r_val;
    logic          r_last;
    logic [16:0]   r_rd_lo;
    logic [16:0]   r_rd_hi;
    logic          r_cmp_valid;
    logic [2:0]    r_cmp_rule;
    logic [7:0]    r_match, n_match;
    logic [31:0]   r_hits [ACTIVE];
    logic [7:0]    verdict_mask;
    logic          out_of_range;

    // Saturate the incoming value and check the addressed rule and field.
    assign sat_value = (i_req.value > Q_ONE) ? Q_ONE : i_req.value;
    assign rule_ok   = ({3'b000, i_req.rule_index} < 6'(RULE_COUNT));
    assign field_ok  = ({2'b00, i_req.field_index} < 5'(FIELD_COUNT));
    assign wr_addr   = AW'(AW'(i_req.rule_index) * FIELD_STEP + AW'(i_req.field_index));

    assign o_status.field_ok = field_ok;
    assign o_status.req_last = i_req.last_field;
    assign o_status.cur_last = r_last;

    // Bound writes.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_bound && rule_ok && field_ok) begin
            if (i_req.action == ACT_WR_LO) begin
                r_lo_mem[wr_addr] <= sat_value;
            end else begin
                r_hi_mem[wr_addr] <= sat_value;
            end
        end
    end

    // Bound reads, one rule per cycle with registered data.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_rd) begin
            r_rd_lo <= r_lo_mem[r_addr];
            r_rd_hi <= r_hi_mem[r_addr];
        end
    end

    // Captured request and the walking read address.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_val  <= sat_value;
            r_last <= i_req.last_field;
            r_addr <= AW'(i_req.field_index);
        end else if (i_cmd.scan_rd) begin
            r_addr <= r_addr + FIELD_STEP;
        end
        r_cmp_rule <= i_cmd.idx;
    end

    // Compare stage behind the memory read.
    assign out_of_range = (r_val < r_rd_lo) || (r_val > r_rd_hi);

    always_comb begin
        n_match = r_match;
        if (i_cmd.emit_verdict) begin
            n_match = 8'hFF;
        end else if (r_cmp_valid && out_of_range) begin
            n_match[r_cmp_rule] = 1'b0;
        end
    end

    assign verdict_mask = r_match & ACTIVE_MASK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_valid <= 1'b0;
            r_match     <= 8'hFF;
        end else begin
            r_cmp_valid <= i_cmd.scan_rd;
            r_match     <= n_match;
        end
    end

    // Per-rule hit counters: saturating bump on a verdict, cleared when reported.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ACTIVE; r++) begin
                r_hits[r] <= '0;
            end
        end else if (i_cmd.emit_verdict) begin
            for (int r = 0; r < ACTIVE; r++) begin
                if (verdict_mask[r] && (r_hits[r] != HITS_MAX)) begin
                    r_hits[r] <= r_hits[r] + 32'd1;
                end
            end
        end else if (i_cmd.emit_count) begin
            r_hits[i_cmd.idx[RW-1:0]] <= '0;
        end
    end

    // Result register and strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_res_strobe <= 1'b0;
        end else begin
            o_res_strobe <= i_cmd.emit_verdict || i_cmd.emit_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_verdict) begin
            o_res.kind        <= KIND_VERDICT;
            o_res.match_mask  <= verdict_mask;
            o_res.rule_number <= 3'd0;
            o_res.match_count <= 32'd0;
            o_res.last        <= 1'b1;
        end else if (i_cmd.emit_count) begin
            o_res.kind        <= KIND_COUNT;
            o_res.match_mask  <= 8'd0;
            o_res.rule_number <= i_cmd.idx;
            o_res.match_count <= r_hits[i_cmd.idx[RW-1:0]];
            o_res.last        <= i_cmd.last_count;
        end
    end

endmodule

/* rtl/multi_rule_range_classifier_unit.sv */
// Range rule classifier: each rule holds an inclusive box of Q1.16 bounds over record fields.
//
// Requests enter on i_req when start is high and busy is low. Bound writes
// (lower or upper) give no result. A record field request is checked
// against each usable rule (RULE_COUNT, at most eight), one rule per cycle
// from the bound memories, so busy stays high through the scan and a drain
// state; a field index at or above FIELD_COUNT skips that check. A field
// that ends a record then passes through an emit state, and its verdict
// (the match mask) strobes on o_res in the cycle after that state. A report
// request keeps busy high while it strobes one count result per usable rule
// in rule order, one a cycle, through the report state and the result
// register; the final one carries last.
// The single read port of each bound memory sets the field rate: one rule
// per cycle. Each result is on o_res for one cycle with o_res_strobe high;
// the receiver takes it then and cannot stall the block. The result register
// lets a new request be accepted while the last result is still shown.
// Reset clears the running match mask to all ones, the hit counters to zero
// and the controller to idle; bounds are unknown until written.
module multi_rule_range_classifier_unit #(
    parameter int FIELD_COUNT = 8,
    parameter int RULE_COUNT  = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  mrrc_pkg::t_req i_req,
    output logic           o_res_strobe,
    output mrrc_pkg::t_res o_res
);
    import mrrc_pkg::*;

    localparam int ACTIVE = (RULE_COUNT < MAX_RULES) ? RULE_COUNT : MAX_RULES;

    t_cmd    cmd;
    t_status status;

    // Control sequencing.
    mrrc_ctrl #(
        .RULE_COUNT (RULE_COUNT)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_req.action),
        .i_status (status),
        .o_busy   (busy),
        .o_cmd    (cmd)
    );

    // Storage, compare and result path.
    mrrc_dp #(
        .FIELD_COUNT (FIELD_COUNT),
        .RULE_COUNT  (RULE_COUNT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res)
    );

`ifndef ASSERT_OFF
    // A bound write does not leave the block busy.
    a_bound_write_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req.action == ACT_WR_LO || i_req.action == ACT_WR_HI))
        |=> !busy)
        else $error("bound write left the block busy");

    // A report keeps the block busy while counts stream out.
    a_report_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.action == ACT_REPORT) |=> busy)
        else $error("report accepted without entering the count sweep");

    // A verdict always closes its run.
    a_verdict_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_res.kind == KIND_VERDICT) |-> o_res.last)
        else $error("verdict without last");

    // Count results only name usable rules.
    a_count_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_res.kind == KIND_COUNT) |-> (int'(o_res.rule_number) < ACTIVE))
        else $error("count result for an unused rule");
`endif

endmodule

/* test/tb_multi_rule_range_classifier_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the range rule classifier unit.
module tb_multi_rule_range_classifier_unit;
    import mrrc_pkg::*;

    localparam int FIELDS     = 8;
    localparam int RULES      = 8;
    localparam int STALL_MAX  = 3000;
    localparam int DRAIN_WAIT = 20;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start   = 1'b0;
    logic  busy;
    t_req  i_req   = '0;
    logic  o_res_strobe;
    t_res  o_res;

    // Mirror of the rule table, the open record and the hit counters.
    logic [16:0] shadow_lower [RULES][FIELDS];
    logic [16:0] shadow_upper [RULES][FIELDS];
    logic [7:0]  shadow_match;
    logic [31:0] shadow_hits  [RULES];

    // Verdicts and counts that the accepted requests still owe.
    t_res outcome_q [$];
    t_res want;
    int   err_count    = 0;
    int   stall_cycles = 0;

    multi_rule_range_classifier_unit #(
        .FIELD_COUNT(FIELDS),
        .RULE_COUNT (RULES)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res_strobe(o_res_strobe),
        .o_res       (o_res)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_req mk_req(input t_action act, input int rule, input int field,
                                    input int val, input bit lf);
        t_req r;
        r.action      = act;
        r.rule_index  = 3'(rule);
        r.field_index = 3'(field);
        r.value       = 17'(val);
        r.last_field  = lf;
        return r;
    endfunction

    // Apply one accepted request to the mirror and queue the results it causes.
    function automatic void classify_request(input t_req r);
        logic [16:0] v;
        t_res        o;
        int          k;
        v = (r.value > Q_ONE) ? Q_ONE : r.value;
        case (r.action)
            ACT_WR_LO: shadow_lower[r.rule_index][r.field_index] = v;
            ACT_WR_HI: shadow_upper[r.rule_index][r.field_index] = v;
            ACT_FIELD: begin
                for (k = 0; k < RULES; k++) begin
                    if (v < shadow_lower[k][r.field_index] ||
                        v > shadow_upper[k][r.field_index])
                        shadow_match[k] = 1'b0;
                end
                if (r.last_field) begin
                    for (k = 0; k < RULES; k++) begin
                        if (shadow_match[k] && shadow_hits[k] != HITS_MAX)
                            shadow_hits[k] = shadow_hits[k] + 1;
                    end
                    o            = '0;
                    o.kind       = KIND_VERDICT;
                    o.match_mask = shadow_match;
                    o.last       = 1'b1;
                    outcome_q.push_back(o);
                    shadow_match = '1;
                end
            end
            default: begin
                for (k = 0; k < RULES; k++) begin
                    o             = '0;
                    o.kind        = KIND_COUNT;
                    o.rule_number = 3'(k);
                    o.match_count = shadow_hits[k];
                    o.last        = (k == RULES - 1);
                    outcome_q.push_back(o);
                    shadow_hits[k] = '0;
                end
            end
        endcase
    endfunction

    // Present one request, with random idle cycles first, and hold it until accepted.
    task automatic send_req(input t_req r, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        i_req <= r;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        classify_request(r);
    endtask

    // Stop sending until every owed result has come back.
    task automatic hold_until_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (outcome_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_error(input string msg);
        err_count++;
        if (err_count <= 10) $display("%s", msg);
    endtask

    // Random bound: lower bounds lean low, upper bounds lean high, some anywhere.
    function automatic int bound_value(input bit upper);
        if ($urandom_range(9) == 0) return $urandom_range(17'h1FFFF);
        return upper ? $urandom_range(33000, 70000) : $urandom_range(0, 32000);
    endfunction

    // Random record value: mostly mid-range, sometimes exactly on a bound, anywhere or at an extreme.
    function automatic int field_value(input int field);
        int rule;
        rule = $urandom_range(RULES - 1);
        case ($urandom_range(9))
            0: return shadow_lower[rule][field];
            1: return shadow_upper[rule][field];
            2: return $urandom_range(17'h1FFFF);
            3: begin
                case ($urandom_range(2))
                    0: return 0;
                    1: return Q_ONE;
                    default: return 17'h1FFFF;
                endcase
            end
            default: return $urandom_range(20000, 50000);
        endcase
    endfunction

    function automatic t_req random_bound_write();
        t_action act;
        act = $urandom_range(1) ? ACT_WR_HI : ACT_WR_LO;
        return mk_req(act, $urandom_range(RULES - 1), $urandom_range(FIELDS - 1),
                      bound_value(act == ACT_WR_HI), $urandom_range(1));
    endfunction

    // Every bound gets written once, as a box covering the whole range.
    task automatic test_load_table();
        int r;
        int f;
        for (r = 0; r < RULES; r++) begin
            for (f = 0; f < FIELDS; f++) begin
                send_req(mk_req(ACT_WR_LO, r, f, 0, 1'b0), 0);
                send_req(mk_req(ACT_WR_HI, r, f, Q_ONE, 1'b0), 0);
            end
        end
    endtask

    // Single point box, crossed bounds, saturated bounds and values, inclusive edges.
    task automatic test_bound_edges();
        send_req(mk_req(ACT_WR_LO, 1, 0, 17'h08000, 1'b0), 0);
        send_req(mk_req(ACT_WR_HI, 1, 0, 17'h08000, 1'b0), 0);
        send_req(mk_req(ACT_WR_LO, 2, 0, 17'h09000, 1'b0), 0);
        send_req(mk_req(ACT_WR_HI, 2, 0, 17'h01000, 1'b1), 0);
        send_req(mk_req(ACT_WR_LO, 3, 0, 17'h18000, 1'b0), 0);
        send_req(mk_req(ACT_WR_HI, 3, 0, 17'h1FFFF, 1'b0), 0);
        send_req(mk_req(ACT_WR_HI, 4, 0, 0, 1'b0), 0);
        send_req(mk_req(ACT_FIELD, 0, 0, 17'h08000, 1'b1), 0);
        send_req(mk_req(ACT_FIELD, 7, 0, 17'h07FFF, 1'b1), 0);
        send_req(mk_req(ACT_FIELD, 5, 0, 17'h1FFFF, 1'b1), 60);
        send_req(mk_req(ACT_FIELD, 2, 0, Q_ONE, 1'b1), 60);
        send_req(mk_req(ACT_FIELD, 3, 0, 0, 1'b1), 0);
    endtask

    // A record that visits every field before it ends, then a report.
    task automatic test_full_record();
        int f;
        for (f = 0; f < FIELDS; f++)
            send_req(mk_req(ACT_FIELD, f, f, (f == 0) ? 17'h08000 : field_value(f),
                            f == FIELDS - 1), 0);
        send_req(mk_req(ACT_REPORT, 0, 0, 0, 1'b0), 0);
    endtask

    // A bound write and a report in the middle of a record leave it open.
    task automatic test_mid_record_traffic();
        send_req(mk_req(ACT_FIELD, 0, 2, 17'h00100, 1'b0), 0);
        send_req(mk_req(ACT_WR_LO, 5, 3, 0, 1'b1), 0);
        send_req(mk_req(ACT_REPORT, 7, 7, 17'h1FFFF, 1'b1), 0);
        send_req(mk_req(ACT_FIELD, 0, 3, Q_ONE, 1'b1), 0);
    endtask

    // Two reports in a row: the second one shows cleared counts.
    task automatic test_back_to_back_reports();
        send_req(mk_req(ACT_FIELD, 1, 1, 17'h0C000, 1'b1), 0);
        send_req(mk_req(ACT_REPORT, 0, 0, 0, 1'b0), 0);
        send_req(mk_req(ACT_REPORT, 0, 0, 0, 1'b0), 0);
    endtask

    // Overwrite a share of the table with random bounds so the match masks vary.
    task automatic test_random_table(input int n_writes);
        int i;
        for (i = 0; i < n_writes; i++)
            send_req(random_bound_write(), 0);
    endtask

    // Mostly whole records with random content, plus bound writes, reports and noise.
    task automatic test_random_traffic(input int n_items, input int idle_pct);
        int sent;
        int pick;
        int nf;
        int j;
        int f;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 78) begin
                nf = ($urandom_range(3) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
                for (j = 0; j < nf; j++) begin
                    if ($urandom_range(19) == 0) begin
                        if ($urandom_range(1))
                            send_req(random_bound_write(), idle_pct);
                        else
                            send_req(mk_req(ACT_REPORT, 0, 0, 0, 1'b0), idle_pct);
                        sent++;
                    end
                    f = $urandom_range(FIELDS - 1);
                    send_req(mk_req(ACT_FIELD, $urandom_range(7), f, field_value(f),
                                    j == nf - 1), idle_pct);
                    sent++;
                end
            end else if (pick < 92) begin
                send_req(random_bound_write(), idle_pct);
                sent++;
            end else begin
                send_req(mk_req(ACT_REPORT, $urandom_range(7), $urandom_range(7),
                                $urandom_range(17'h1FFFF), $urandom_range(1)), idle_pct);
                sent++;
            end
        end
    endtask

    // Compare each strobed result with the oldest owed one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_strobe === 1'b1) begin
            if (outcome_q.size() == 0) begin
                report_error($sformatf({"unexpected result: kind=%0d mask=%02h rule=%0d ",
                             "count=%0d last=%0d"},
                             o_res.kind, o_res.match_mask, o_res.rule_number,
                             o_res.match_count, o_res.last));
            end else begin
                want = outcome_q.pop_front();
                if (o_res.kind !== want.kind || o_res.match_mask !== want.match_mask ||
                    o_res.rule_number !== want.rule_number ||
                    o_res.match_count !== want.match_count || o_res.last !== want.last)
                    report_error($sformatf({"mismatch: expected kind=%0d mask=%02h rule=%0d ",
                                 "count=%0d last=%0d, got kind=%0d mask=%02h rule=%0d ",
                                 "count=%0d last=%0d"},
                                 want.kind, want.match_mask, want.rule_number,
                                 want.match_count, want.last,
                                 o_res.kind, o_res.match_mask, o_res.rule_number,
                                 o_res.match_count, o_res.last));
            end
        end
    end

    // Watchdog: too many cycles without an accepted request or a result.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_res_strobe === 1'b1) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_MAX) begin
            $display("[multi_rule_range_classifier_unit] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Test sequence.
    initial begin
        shadow_match = '1;
        foreach (shadow_hits[k]) shadow_hits[k] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_load_table();
        test_bound_edges();
        test_full_record();
        test_mid_record_traffic();
        test_back_to_back_reports();
        hold_until_drained();
        test_random_table(48);
        test_random_traffic(40, 0);
        hold_until_drained();
        test_random_traffic(40, 60);
        hold_until_drained();
        test_random_traffic(36, 27);
        start <= 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_count == 0)
            $display("[multi_rule_range_classifier_unit] OK");
        else
            $display("[multi_rule_range_classifier_unit] ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/mrrc_pkg.sv
rtl/mrrc_ctrl.sv
rtl/mrrc_dp.sv
rtl/multi_rule_range_classifier_unit.sv
test/tb_multi_rule_range_classifier_unit.sv
